>>> rtl/core/sclau_pkg.sv
package sclau_pkg;

  localparam int STORE_BYTES = 64;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CAP_W       = 7;
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [2:0] REG_LINE_CAPACITY = 3'd0;

  typedef struct packed {
    logic              term;
    logic [BYTE_W-1:0] ch;
  } cmd_t;

endpackage

>>> rtl/core/sclau_front.sv
module sclau_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sclau_pkg::BYTE_W-1:0] in_byte,
  output logic                       push,
  output sclau_pkg::cmd_t            push_cmd,
  input  logic                       push_ready
);

  logic            slot_v_r;
  logic            slot_v_nxt;
  sclau_pkg::cmd_t slot_r;
  sclau_pkg::cmd_t slot_nxt;
  logic            accept;

  assign push      = slot_v_r;
  assign push_cmd  = slot_r;
  assign in_tready = !slot_v_r || push_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    slot_v_nxt = slot_v_r && !push_ready;
    slot_nxt   = slot_r;
    if (accept) begin
      slot_v_nxt    = 1'b1;
      slot_nxt.ch   = in_byte;
      slot_nxt.term = (in_byte == sclau_pkg::CHAR_CR) || (in_byte == sclau_pkg::CHAR_LF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
    end else begin
      slot_v_r <= slot_v_nxt;
    end
    slot_r <= slot_nxt;
  end

endmodule

>>> rtl/core/sclau_cmdq.sv
module sclau_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sclau_pkg::cmd_t push_cmd,
  output logic            push_ready,
  input  logic            pop,
  output logic            pop_valid,
  output sclau_pkg::cmd_t pop_cmd
);

  sclau_pkg::cmd_t                entry_r [sclau_pkg::QDEPTH];
  logic [sclau_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [sclau_pkg::QPTR_W-1:0]   wr_ptr_nxt;
  logic [sclau_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [sclau_pkg::QPTR_W-1:0]   rd_ptr_nxt;
  logic [sclau_pkg::QPTR_W:0]     fill_r;
  logic [sclau_pkg::QPTR_W:0]     fill_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (fill_r != (sclau_pkg::QPTR_W+1)'(sclau_pkg::QDEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/sclau_back.sv
module sclau_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sclau_pkg::CAP_W-1:0]   line_capacity,
  input  logic                          cmd_valid,
  input  sclau_pkg::cmd_t               cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sclau_pkg::BYTE_W-1:0]  out_byte,
  output logic [sclau_pkg::LEN_W-1:0]   out_len,
  output logic                          out_last
);

  localparam int CMP_W = ((sclau_pkg::ADDR_W > sclau_pkg::CAP_W) ?
                          sclau_pkg::ADDR_W : sclau_pkg::CAP_W) + 1;
  localparam logic [sclau_pkg::ADDR_W-1:0] HELD_MAX =
    sclau_pkg::ADDR_W'(sclau_pkg::STORE_BYTES - 1);

  typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

  state_t                          state_r, state_nxt;
  logic [sclau_pkg::ADDR_W-1:0]    held_r, held_nxt;
  logic [sclau_pkg::ADDR_W-1:0]    len_r, len_nxt;
  logic [sclau_pkg::ADDR_W-1:0]    idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [sclau_pkg::BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic [sclau_pkg::LEN_W-1:0]     out_len_r, out_len_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [sclau_pkg::BYTE_W-1:0]    store_r [sclau_pkg::STORE_BYTES];
  logic [sclau_pkg::BYTE_W-1:0]    rd_data_r;
  logic                            rd_en;
  logic [sclau_pkg::ADDR_W-1:0]    rd_addr;
  logic                            wr_en;

  logic [CMP_W-1:0]                held_ext;
  logic [CMP_W-1:0]                cap_ext;
  logic [sclau_pkg::ADDR_W-1:0]    cut_len;
  logic                            load;
  logic                            at_last;

  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_len   = out_len_r;
  assign out_last  = out_last_r;
  assign load      = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign at_last   = (idx_r == len_r - sclau_pkg::ADDR_W'(1));

  always_comb begin
    held_ext = CMP_W'(held_r);
    cap_ext  = CMP_W'(line_capacity);
    if (cap_ext < CMP_W'(2)) begin
      cut_len = '0;
    end else if (held_ext > cap_ext - CMP_W'(1)) begin
      cut_len = sclau_pkg::ADDR_W'(cap_ext - CMP_W'(1));
    end else begin
      cut_len = held_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    if (cmd_pop) begin
      if (cmd.term) begin
        if (held_r != '0) begin
          held_nxt = '0;
          len_nxt  = cut_len;
          if (cut_len != '0) begin
            state_nxt = ST_DRAIN;
            idx_nxt   = '0;
            rd_en     = 1'b1;
          end
        end
      end else if (held_r != HELD_MAX) begin
        wr_en    = 1'b1;
        held_nxt = held_r + 1'b1;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rd_data_r;
      out_len_nxt   = sclau_pkg::LEN_W'(len_r);
      out_last_nxt  = at_last;
      if (at_last) begin
        state_nxt = ST_IDLE;
      end else begin
        idx_nxt = idx_r + 1'b1;
        rd_en   = 1'b1;
        rd_addr = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[held_r] <= cmd.ch;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_MAX)
    else $error("held count beyond store capacity");

  a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (idx_r < len_r))
    else $error("drain index past line length");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (held_r == '0))
    else $error("bytes held while a line drains");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && at_last) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("drain did not finish on the last item");

endmodule

>>> rtl/core/serial_command_line_assembler_unit.sv
// Command line assembler for a received byte stream.
// The in_ channel carries one received byte per item. Ordinary bytes are
// held in a 64-byte line store, up to 63 of them; later bytes of an
// over-long line are dropped. A CR or LF item ends the line: an empty line
// gives nothing, otherwise the held bytes leave on the out_ channel, one
// item per byte, cut to line_capacity minus one bytes, each tagged with the
// line length and with tlast on the final byte.
// Input items are taken one per cycle while the four-entry command queue
// has room. A line drains at one item per cycle while out_tready is high,
// from the single read port of the line store; out_tvalid first rises once
// the terminator has passed the front slot, the command queue, the store
// read register and the output register. While a line drains the queue
// fills and the input stalls. When the receiver holds out_tready low the
// drain waits in place and no item is lost. Reset empties the queue, clears
// the held count and sets line_capacity to 64; no clearing pass is needed.
// line_capacity is written over the APB-style cfg_ port at addresses 0 to 3.
module serial_command_line_assembler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [13:8] line_length, [15:14] zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [sclau_pkg::CAP_W-1:0]  cap_r;
  logic [sclau_pkg::CAP_W-1:0]  cap_nxt;
  logic                         cfg_wr;
  logic                         cfg_sel0;

  logic                         q_push;
  sclau_pkg::cmd_t              q_push_cmd;
  logic                         q_push_ready;
  logic                         q_pop;
  logic                         q_valid;
  sclau_pkg::cmd_t              q_cmd;

  logic [sclau_pkg::BYTE_W-1:0] res_byte;
  logic [sclau_pkg::LEN_W-1:0]  res_len;

  assign cfg_pready = 1'b1;
  assign cfg_sel0   = ({cfg_paddr[2], 2'b00} == sclau_pkg::REG_LINE_CAPACITY);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_sel0 ? {25'd0, cap_r} : 32'd0;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_wr && cfg_sel0) begin
      cap_nxt = cfg_pwdata[sclau_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= sclau_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  sclau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .push_ready (q_push_ready)
  );

  sclau_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd)
  );

  sclau_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .line_capacity (cap_r),
    .cmd_valid     (q_valid),
    .cmd           (q_cmd),
    .cmd_pop       (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_byte      (res_byte),
    .out_len       (res_len),
    .out_last      (out_tlast)
  );

  assign out_tdata = {2'b00, res_len, res_byte};

endmodule

>>> tb/sv/tb.sv
module tb;

  localparam int DRAIN_PAD   = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 3;
  localparam int PRESS_ITEMS = 72;
  localparam int LONG_LINE   = 64;

  typedef enum {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum {RX_OPEN, RX_COIN, RX_BEAT, RX_CHOKE} rx_mode_t;

  typedef struct {
    logic [7:0] ch;
    logic [5:0] len;
    logic       last;
  } line_res_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] val;
    bit         typed;
    int         n_out;
    logic [7:0] ch;
    logic [5:0] len;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  serial_command_line_assembler_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  logic [7:0] held_bytes [sclau_pkg::STORE_BYTES];
  int         held_n;
  int         shadow_cap;
  line_res_t  pending_chars [$];

  int errors;
  int cyc_count;
  int n_items;
  int n_lines;
  int n_checked;
  int holds_asked;
  int holds_done;
  int burst_left;
  bit steady;

  stim_row_t dir_rows [29] = '{
    '{ROW_BYTE, 8'h0D, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0A, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h41, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0D, 1'b1, 1, 8'h41, 6'd1},
    '{ROW_BYTE, 8'h00, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0A, 1'b1, 1, 8'h00, 6'd1},
    '{ROW_BYTE, 8'hFF, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0D, 1'b1, 1, 8'hFF, 6'd1},
    '{ROW_BYTE, 8'h0C, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0E, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h09, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0B, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h80, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0A, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_CFG,  8'd2,  1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h42, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h43, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0D, 1'b1, 1, 8'h42, 6'd1},
    '{ROW_CFG,  8'd1,  1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h44, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0A, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_CFG,  8'd0,  1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h45, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0D, 1'b1, 0, 8'h00, 6'd0},
    '{ROW_CFG,  8'd127, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h46, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h47, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_BYTE, 8'h0A, 1'b0, 0, 8'h00, 6'd0},
    '{ROW_CFG,  8'd64, 1'b0, 0, 8'h00, 6'd0}
  };

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cyc_count, msg);
    errors++;
  endtask

  function automatic void assemble_byte(input logic [7:0] b, ref line_res_t res[$]);
    int        n;
    line_res_t r;
    res.delete();
    if (b == sclau_pkg::CHAR_CR || b == sclau_pkg::CHAR_LF) begin
      if (held_n == 0) return;
      n = held_n;
      if (shadow_cap < 2) n = 0;
      else if (n > shadow_cap - 1) n = shadow_cap - 1;
      held_n = 0;
      for (int i = 0; i < n; i++) begin
        r.ch   = held_bytes[i];
        r.len  = 6'(n);
        r.last = (i == n - 1);
        res.push_back(r);
      end
    end else if (held_n < sclau_pkg::STORE_BYTES - 1) begin
      held_bytes[held_n] = b;
      held_n++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_byte(input logic [7:0] b, input bit typed, input int n_typed,
                           input line_res_t typed_res);
    int        gap;
    line_res_t line [$];
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    assemble_byte(b, line);
    if (typed) begin
      line.delete();
      if (n_typed > 0) line.push_back(typed_res);
    end
    if (line.size() > 0) n_lines++;
    foreach (line[i]) pending_chars.push_back(line[i]);
    n_items++;
    @(negedge clk);
  endtask

  // The pad covers a line that was cut to nothing and is still being cleared.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] cap);
    logic [31:0] rd;
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= sclau_pkg::REG_LINE_CAPACITY;
    cfg_pwdata  <= {25'($urandom()), cap};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_cap = int'(cap);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[6:0] !== cap)
      report($sformatf("line_capacity read back %0d, wrote %0d", rd[6:0], cap));
  endtask

  always @(posedge clk) begin
    line_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected item byte %02h", out_tdata[7:0]));
      end else begin
        want = pending_chars.pop_front();
        n_checked++;
        if (out_tdata[7:0] !== want.ch)
          report($sformatf("out_byte %02h, expected %02h", out_tdata[7:0], want.ch));
        if (out_tdata[13:8] !== want.len)
          report($sformatf("line_length %0d, expected %0d", out_tdata[13:8], want.len));
        if (out_tlast !== want.last)
          report($sformatf("tlast %b, expected %b", out_tlast, want.last));
        if (out_tdata[15:14] !== 2'b00)
          report($sformatf("padding bits %b", out_tdata[15:14]));
      end
    end
  end

  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count == CYCLE_LIMIT) begin
      $display("timeout with %0d items still expected", pending_chars.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own and takes long hold-offs on request.
  always @(negedge clk) begin
    int       hold_left;
    int       mode_left;
    int       rx_tick;
    rx_mode_t rx_mode;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
        RX_BEAT:  out_tready <= (rx_tick % 3 != 0);
        default:  out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    line_res_t  typed_res;
    line_res_t  no_res;
    logic [6:0] phase_caps [8];
    int         sent;
    int         len;
    logic [7:0] b;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    errors      = 0;
    cyc_count   = 0;
    n_items     = 0;
    n_lines     = 0;
    n_checked   = 0;
    holds_asked = 0;
    holds_done  = 0;
    burst_left  = 0;
    steady      = 1'b0;
    held_n      = 0;
    shadow_cap  = int'(sclau_pkg::CAP_RESET);
    no_res      = '{8'h00, 6'd0, 1'b0};
    foreach (held_bytes[i]) held_bytes[i] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        wait_drained();
        write_capacity(dir_rows[k].val[6:0]);
      end else begin
        typed_res = '{dir_rows[k].ch, dir_rows[k].len, 1'b1};
        send_byte(dir_rows[k].val, dir_rows[k].typed, dir_rows[k].n_out, typed_res);
      end
    end

    phase_caps = '{7'd64, 7'd2, 7'd127, 7'd1, 7'd0, 7'd17, 7'd96,
                   7'($urandom_range(2, 64))};
    foreach (phase_caps[ph]) begin
      wait_drained();
      write_capacity(phase_caps[ph]);
      steady = (ph == 2);
      if (ph == 0) holds_asked++;
      sent = 0;
      while (sent < ((ph == 0) ? PRESS_ITEMS : PHASE_ITEMS)) begin
        if (ph == 0 && sent == 0) len = LONG_LINE;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(17, 20);
        else len = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            b = 8'($urandom_range(0, 255));
          end else begin
            do b = 8'($urandom_range(0, 255));
            while (b == sclau_pkg::CHAR_CR || b == sclau_pkg::CHAR_LF);
          end
          send_byte(b, 1'b0, 0, no_res);
          sent++;
        end
        send_byte($urandom_range(0, 1) ? sclau_pkg::CHAR_CR : sclau_pkg::CHAR_LF,
                  1'b0, 0, no_res);
        sent++;
        if ($urandom_range(0, 2) == 0) begin
          send_byte(sclau_pkg::CHAR_LF, 1'b0, 0, no_res);
          sent++;
        end
      end
    end
    steady = 1'b0;

    wait_drained();
    $display("Sent %0d bytes under eight line capacities; %0d lines produced output.",
             n_items, n_lines);
    $display("Checked %0d output items, with %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
